// ----- sv/sha1bc_pkg.sv -----
// Package with the word types, state encoding and SHA-1 constants of the compression block.
`timescale 1ns / 1ps

package sha1bc_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic        new_message;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_word_t;

  // Five 32-bit words; element 0 is a (or H0), element 4 is e (or H4).
  typedef logic [4:0][31:0] vars_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_EMIT
  } state_t;

  localparam logic [3:0] LAST_LOAD  = 4'd15;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam vars_t IV_WORDS = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

endpackage

// ----- sv/sha1bc_round.sv -----
// One SHA-1 round: round function, round constant and the five-operand add.
`timescale 1ns / 1ps

module sha1bc_round (
  input  sha1bc_pkg::vars_t vin,
  input  logic [31:0]       wt,
  input  logic [6:0]        rnd,
  output sha1bc_pkg::vars_t vout
);
  import sha1bc_pkg::*;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, tmp;

  assign a = vin[0];
  assign b = vin[1];
  assign c = vin[2];
  assign d = vin[3];
  assign e = vin[4];

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + wt + k;

  assign vout[0] = tmp;
  assign vout[1] = a;
  assign vout[2] = {b[1:0], b[31:2]};
  assign vout[3] = c;
  assign vout[4] = d;

endmodule

// ----- sv/sha1_block_compress_top.sv -----
// Top level of the SHA-1 block compression engine with a kept chaining hash.
`timescale 1ns / 1ps

// The block takes sixteen 32-bit message words per 512-bit block, one word per cycle while
// msg_stall is low, and then runs the 80 SHA-1 rounds through a single shared round unit,
// one round per cycle, while msg_stall is high. It then adds the working variables into
// the chaining hash with one adder, one hash word per cycle unless the digest channel
// stalls, and presents H0 through H4 on the digest channel. Message words for the next
// block are taken as soon as the last digest word sits in the output register. A word
// with new_message set makes its block start from the standard initial values.

module sha1_block_compress_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  sha1bc_pkg::msg_word_t msg,
  output logic                  dig_valid,
  input  logic                  dig_stall,
  output sha1bc_pkg::dig_word_t dig
);
  import sha1bc_pkg::*;

  state_t      state, state_next;
  logic [3:0]  cnt;
  logic [6:0]  rnd;
  logic [2:0]  idx;
  logic        restart;
  vars_t       chain;
  vars_t       wv;
  vars_t       wv_next;
  logic [31:0] sw [16];
  logic [31:0] sw_new;
  logic [31:0] sum;
  logic        msg_take;
  logic        dig_take;
  logic        emit;
  logic        restart_eff;
  vars_t       base;

  sha1bc_round u_round (
    .vin  (wv),
    .wt   (sw[0]),
    .rnd  (rnd),
    .vout (wv_next)
  );

  assign msg_take    = msg_valid && !msg_stall;
  assign dig_take    = dig_valid && !dig_stall;
  assign sw_new      = {sw[13][30:0] ^ sw[8][30:0] ^ sw[2][30:0] ^ sw[0][30:0],
                        sw[13][31] ^ sw[8][31] ^ sw[2][31] ^ sw[0][31]};
  assign restart_eff = restart || msg.new_message;
  assign base        = restart_eff ? IV_WORDS : chain;
  assign sum         = chain[idx] + wv[idx];

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (msg_take && cnt == LAST_LOAD) state_next = ST_ROUND;
      ST_ROUND: if (rnd == LAST_ROUND) state_next = ST_EMIT;
      ST_EMIT:  if (emit && idx == LAST_INDEX) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    msg_stall = 1'b1;
    emit      = 1'b0;
    case (state)
      ST_LOAD:  msg_stall = 1'b0;
      ST_ROUND: msg_stall = 1'b1;
      ST_EMIT:  emit = !dig_valid || !dig_stall;
      default:  msg_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      rnd       <= '0;
      idx       <= '0;
      restart   <= 1'b0;
      chain     <= IV_WORDS;
      dig_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (msg_take) begin
        cnt <= cnt + 4'd1;
        if (cnt == LAST_LOAD) begin
          restart <= 1'b0;
          chain   <= base;
        end else begin
          restart <= restart_eff;
        end
      end
      if (state == ST_ROUND) begin
        rnd <= (rnd == LAST_ROUND) ? '0 : rnd + 7'd1;
      end
      if (emit) begin
        chain[idx] <= sum;
        idx        <= (idx == LAST_INDEX) ? '0 : idx + 3'd1;
        dig_valid  <= 1'b1;
      end else if (dig_take) begin
        dig_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_take) begin
      for (int i = 0; i < 15; i++) begin
        sw[i] <= sw[i + 1];
      end
      sw[15] <= msg.message_word;
      if (cnt == LAST_LOAD) begin
        wv <= base;
      end
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sw[i] <= sw[i + 1];
      end
      sw[15] <= sw_new;
      wv     <= wv_next;
    end
    if (emit) begin
      dig.digest_word <= sum;
      dig.word_index  <= idx;
      dig.last_word   <= (idx == LAST_INDEX);
    end
  end

endmodule

// ----- sv/sha1bc_chk.sv -----
// Port checker for the SHA-1 compression top level and its bind statement.
`timescale 1ns / 1ps

module sha1bc_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  msg_stall,
  input logic                  dig_valid,
  input logic                  dig_stall,
  input sha1bc_pkg::dig_word_t dig
);
  import sha1bc_pkg::*;

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> dig.word_index <= LAST_INDEX)
    else $error("Digest word index out of range.");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig.last_word == (dig.word_index == LAST_INDEX)))
    else $error("Last flag does not match the digest word index.");

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig.word_index < 3'd3 |=> msg_stall)
    else $error("Message words accepted before the digest is fully issued.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_stall |=> dig_valid && $stable(dig))
    else $error("Stalled digest word changed.");

endmodule

bind sha1_block_compress_top sha1bc_chk u_chk (.*);

// ----- tb/sv/sha1_digest_checker.sv -----
// Checker that predicts the SHA-1 chaining digests from the accepted message words and compares them.
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  input  logic                  msg_stall,
  input  sha1bc_pkg::msg_word_t msg,
  input  logic                  dig_valid,
  input  logic                  dig_stall,
  input  sha1bc_pkg::dig_word_t dig,
  output int                    error_count,
  output int                    digests_waiting
);

  import sha1bc_pkg::*;

  vars_t             hash_state;
  logic [15:0][31:0] block_words;
  logic [3:0]        word_count;
  logic              restart_flag;
  dig_word_t         expected_digests[$];
  dig_word_t         digest;
  dig_word_t         want;
  vars_t             base;
  int                i;

  function automatic vars_t sha1_compress(input vars_t start, input logic [15:0][31:0] blk);
    logic [15:0][31:0] w;
    logic [31:0] a, b, c, d, e, f, k, t_sum, x;
    vars_t next_hash;
    int t;
    w = blk;
    a = start[0];
    b = start[1];
    c = start[2];
    d = start[3];
    e = start[4];
    for (t = 0; t < 80; t++) begin
      if (t >= 16) begin
        x = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
        w[t % 16] = {x[30:0], x[31]};
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t_sum = {a[26:0], a[31:27]} + f + e + w[t % 16] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t_sum;
    end
    next_hash[0] = start[0] + a;
    next_hash[1] = start[1] + b;
    next_hash[2] = start[2] + c;
    next_hash[3] = start[3] + d;
    next_hash[4] = start[4] + e;
    return next_hash;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      hash_state = IV_WORDS;
      block_words = '0;
      word_count = '0;
      restart_flag = 1'b0;
      expected_digests.delete();
      error_count = 0;
    end else begin
      if (dig_valid && !dig_stall) begin
        if (expected_digests.size() == 0) begin
          $error("unexpected digest word %h (index %0d)", dig.digest_word, dig.word_index);
          error_count++;
        end else begin
          want = expected_digests.pop_front();
          if (dig.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, actual %h", want.digest_word, dig.digest_word);
            error_count++;
          end
          if (dig.word_index !== want.word_index) begin
            $error("word_index: expected %0d, actual %0d", want.word_index, dig.word_index);
            error_count++;
          end
          if (dig.last_word !== want.last_word) begin
            $error("last_word: expected %b, actual %b", want.last_word, dig.last_word);
            error_count++;
          end
        end
      end
      if (msg_valid && !msg_stall) begin
        if (msg.new_message) begin
          restart_flag = 1'b1;
        end
        block_words[word_count] = msg.message_word;
        word_count = word_count + 4'd1;
        if (word_count == 4'd0) begin
          base = restart_flag ? IV_WORDS : hash_state;
          hash_state = sha1_compress(base, block_words);
          restart_flag = 1'b0;
          for (i = 0; i < 5; i++) begin
            digest.digest_word = hash_state[i];
            digest.word_index = 3'(i);
            digest.last_word = (3'(i) == LAST_INDEX);
            expected_digests.push_back(digest);
          end
        end
      end
    end
    digests_waiting = expected_digests.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the SHA-1 block compression testbench: clock, reset, word stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module testbench;

  import sha1bc_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int TOTAL_WORDS = 256;
  localparam int PAUSE_AT    = 144;
  localparam int LONG_HOLD   = 400;

  logic      clk;
  logic      rst = 1'b1;
  logic      msg_valid = 1'b0;
  logic      msg_stall;
  msg_word_t msg = '0;
  logic      dig_valid;
  logic      dig_stall = 1'b0;
  dig_word_t dig;

  int error_count;
  int digests_waiting;
  int burst_left = 0;
  int idle_cycles = 0;
  int digests_taken = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  logic held_once = 1'b0;

  sha1_block_compress_top dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  sha1_digest_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .msg_valid       (msg_valid),
    .msg_stall       (msg_stall),
    .msg             (msg),
    .dig_valid       (dig_valid),
    .dig_stall       (dig_stall),
    .dig             (dig),
    .error_count     (error_count),
    .digests_waiting (digests_waiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (dig_valid && !dig_stall) begin
        digests_taken <= digests_taken + 1;
      end
      if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver holds off once for a long stretch so that the block fills up.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      dig_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held_once && digests_taken >= 12) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD;
      dig_stall <= 1'b1;
    end else begin
      dig_stall <= (rx_cycle % 64 >= 16) && ($urandom_range(0, 2) == 0);
    end
  end

  task automatic offer_word(input msg_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        msg_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    msg <= w;
    msg_valid <= 1'b1;
    do @(posedge clk); while (msg_stall);
    @(negedge clk);
  endtask

  initial begin
    msg_word_t w;
    int sent;
    int i;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A flagged block of alternating extreme words.
    for (i = 0; i < 16; i++) begin
      w.message_word = i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
      w.new_message = (i == 0);
      offer_word(w);
    end
    // The next block carries its restart flag on a later word.
    for (i = 0; i < 9; i++) begin
      w.message_word = 32'h1 << (3 * i);
      w.new_message = (i == 6);
      offer_word(w);
    end

    sent = 25;
    while (sent < TOTAL_WORDS) begin
      if (sent == PAUSE_AT) begin
        msg_valid <= 1'b0;
        do @(negedge clk); while (digests_waiting != 0);
      end
      case ($urandom_range(0, 7))
        0: w.message_word = 32'h0000_0000;
        1: w.message_word = 32'hFFFF_FFFF;
        default: w.message_word = $urandom();
      endcase
      if (sent % 16 == 0) begin
        w.new_message = ($urandom_range(0, 4) < 2);
      end else begin
        w.new_message = ($urandom_range(0, 31) == 0);
      end
      offer_word(w);
      sent++;
    end

    msg_valid <= 1'b0;
    do @(negedge clk); while (digests_waiting != 0);
    repeat (120) @(negedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
